// ----- sv/htqs_pkg.sv -----
// Shared types, constants and byte-class functions for the HTTP token /
// quoted-string lexer. No dependencies.
package htqs_pkg;

   localparam int MAX_FIELD_LEN = 4096;
   localparam int LEN_W         = 13;
   localparam int LEN_CAP_INT   = (MAX_FIELD_LEN < 8191) ? MAX_FIELD_LEN : 8191;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // scan kinds
   localparam logic [1:0] KIND_WS     = 2'd0;
   localparam logic [1:0] KIND_TOKEN  = 2'd1;
   localparam logic [1:0] KIND_QUOTED = 2'd2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_HT     = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef struct packed {
      logic ws;        // space or tab
      logic token;     // token character
      logic quote;
      logic bslash;
      logic qdtext;    // plain string-body byte
      logic esc_ok;    // legal byte after a backslash (1..127)
   } class_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       begin_req;
      logic [7:0] data_byte;
      class_type  cls;
   } item_type;

   function automatic logic is_separator(input logic [7:0] c);
      logic r;
      unique case (c)
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
         8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic class_type classify(input logic [7:0] c);
      class_type k;
      k.ws     = (c == CH_SP) || (c == CH_HT);
      k.token  = (c > CH_SP) && (c <= CH_TILDE) && !is_separator(c);
      k.quote  = (c == CH_QUOTE);
      k.bslash = (c == CH_BSLASH);
      k.qdtext = (c == CH_HT) || (c == CH_CR) || (c == CH_LF) || c[7]
                 || ((c >= CH_SP) && (c <= CH_TILDE)
                     && (c != CH_QUOTE) && (c != CH_BSLASH));
      k.esc_ok = (c != CH_NUL) && !c[7];
      return k;
   endfunction

endpackage

// ----- sv/htqs_front.sv -----
// Front stage: takes input items, decodes the byte class and holds the
// item in a register until the queue takes it. Depends on htqs_pkg.
module htqs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic              req_begin_req,
   input  logic [7:0]        req_data_byte,
   output logic              push_valid,
   input  logic              push_ready,
   output htqs_pkg::item_type push_item
);
   import htqs_pkg::*;

   logic     stg_valid_ff, stg_valid_in;
   item_type stg_item_ff, stg_item_in;
   logic     take;

   assign req_ready = !stg_valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      stg_valid_in = take || (stg_valid_ff && !push_ready);
      stg_item_in  = stg_item_ff;
      if (take) begin
         stg_item_in.kind      = req_kind;
         stg_item_in.begin_req = req_begin_req;
         stg_item_in.data_byte = req_data_byte;
         stg_item_in.cls       = classify(req_data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      stg_item_ff <= stg_item_in;
   end

   assign push_valid = stg_valid_ff;
   assign push_item  = stg_item_ff;

endmodule

// ----- sv/htqs_queue.sv -----
// Short FIFO of classified items between front and back stages.
// Depends on htqs_pkg.
module htqs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  htqs_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output htqs_pkg::item_type pop_item
);
   import htqs_pkg::*;

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/htqs_back.sv -----
// Back stage: scan-phase machine and length counter; one result per item
// into the output register. Depends on htqs_pkg.
module htqs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  htqs_pkg::item_type pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_out_valid,
   output logic               rsp_consumed,
   output logic               rsp_finished,
   output logic               rsp_not_found,
   output logic [htqs_pkg::LEN_W-1:0] rsp_field_length
);
   import htqs_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WS    = 3'd1;
   localparam logic [2:0] PH_TOKEN = 3'd2;
   localparam logic [2:0] PH_QOPEN = 3'd3;
   localparam logic [2:0] PH_QBODY = 3'd4;
   localparam logic [2:0] PH_QESC  = 3'd5;

   logic [2:0]       phase_ff, phase_in, phase_eff;
   logic [LEN_W-1:0] count_ff, count_in, cnt_base, cnt_inc;
   logic             valid_ff, valid_in, step;
   logic [7:0]       obyte_ff, obyte_in;
   logic             ovalid_ff, ovalid_in, cons_ff, cons_in;
   logic             fin_ff, fin_in, nf_ff, nf_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       c;
   class_type        k;

   assign pop_ready = !valid_ff || rsp_ready;
   assign step      = pop_valid && pop_ready;
   assign c         = pop_item.data_byte;
   assign k         = pop_item.cls;

   always_comb begin
      cnt_base  = pop_item.begin_req ? '0 : count_ff;
      cnt_inc   = (cnt_base < LEN_CAP) ? cnt_base + 1'b1 : cnt_base;
      phase_eff = phase_ff;
      fin_in    = 1'b0;
      nf_in     = 1'b0;
      cons_in   = 1'b0;
      ovalid_in = 1'b0;
      obyte_in  = '0;
      if (pop_item.begin_req) begin
         unique case (pop_item.kind)
            KIND_WS:     phase_eff = PH_WS;
            KIND_TOKEN:  phase_eff = PH_TOKEN;
            KIND_QUOTED: phase_eff = PH_QOPEN;
            default: begin
               // undefined kind: fail at once, byte not consumed
               phase_eff = PH_IDLE;
               fin_in    = 1'b1;
               nf_in     = 1'b1;
            end
         endcase
      end
      phase_in = phase_eff;
      count_in = cnt_base;
      unique case (phase_eff)
         PH_WS: begin
            if (k.ws) begin
               cons_in = 1'b1;
            end else begin
               fin_in   = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_TOKEN: begin
            if (k.token) begin
               cons_in   = 1'b1;
               ovalid_in = 1'b1;
               obyte_in  = c;
               count_in  = cnt_inc;
            end else begin
               fin_in   = 1'b1;
               nf_in    = (cnt_base == '0);
               phase_in = PH_IDLE;
            end
         end
         PH_QOPEN: begin
            if (k.quote) begin
               cons_in  = 1'b1;
               phase_in = PH_QBODY;
            end else begin
               fin_in   = 1'b1;
               nf_in    = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_QBODY: begin
            if (k.quote) begin
               cons_in  = 1'b1;
               fin_in   = 1'b1;
               phase_in = PH_IDLE;
            end else if (k.bslash) begin
               cons_in  = 1'b1;
               phase_in = PH_QESC;
            end else if (k.qdtext) begin
               cons_in   = 1'b1;
               ovalid_in = 1'b1;
               obyte_in  = c;
               count_in  = cnt_inc;
            end else begin
               fin_in   = 1'b1;
               nf_in    = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_QESC: begin
            if (k.esc_ok) begin
               cons_in   = 1'b1;
               ovalid_in = 1'b1;
               obyte_in  = c;
               count_in  = cnt_inc;
               phase_in  = PH_QBODY;
            end else begin
               fin_in   = 1'b1;
               nf_in    = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      len_in   = count_in;
      valid_in = step || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
      end
      if (step) begin
         obyte_ff  <= obyte_in;
         ovalid_ff <= ovalid_in;
         cons_ff   <= cons_in;
         fin_ff    <= fin_in;
         nf_ff     <= nf_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = obyte_ff;
   assign rsp_out_valid    = ovalid_ff;
   assign rsp_consumed     = cons_ff;
   assign rsp_finished     = fin_ff;
   assign rsp_not_found    = nf_ff;
   assign rsp_field_length = len_ff;

endmodule

// ----- sv/http_token_quoted_string_lexer_core.sv -----
// HTTP token / quoted-string / whitespace lexer, one byte per item.
// Path from req accept to rsp_valid: front register, queue, output
// register. Throughput: one item per cycle while rsp_ready holds; the
// 4-entry queue absorbs output stalls.
// Reset (synchronous): scan phase idle, length count zero, all stages empty.
// Depends on htqs_pkg, htqs_front, htqs_queue, htqs_back.
module http_token_quoted_string_lexer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic       req_begin_req,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_consumed,
   output logic       rsp_finished,
   output logic       rsp_not_found,
   output logic [htqs_pkg::LEN_W-1:0] rsp_field_length
);
   import htqs_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   htqs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_begin_req (req_begin_req),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   htqs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   htqs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_consumed     (rsp_consumed),
      .rsp_finished     (rsp_finished),
      .rsp_not_found    (rsp_not_found),
      .rsp_field_length (rsp_field_length)
   );

   a_nf_needs_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_found |-> rsp_finished)
      else $error("not_found without finished");

   a_emit_consumes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_consumed && !rsp_finished)
      else $error("content byte emitted on unconsumed or final item");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == '0)
      else $error("out_byte nonzero without out_valid");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_field_length <= LEN_CAP)
      else $error("field length above cap");

endmodule
